[rtl/qsl_pkg.sv]
// Package for the quicksort unit: sizes, state encoding.
`default_nettype none
package qsl_pkg;
  localparam int MAX_ELEMENTS = 64;
  localparam int STACK_DEPTH  = 64;
  localparam int DATA_W       = 32;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int SP_W         = $clog2(STACK_DEPTH) + 1;
  localparam int RANGE_W      = 2 * IDX_W;
  localparam int CMP_W        = 12;
  localparam int SWP_W        = 12;
  localparam int ACC_W        = 13;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_POP, S_POPW, S_PIV, S_CMP, S_SWR, S_SWW,
    S_NEXT, S_FIN, S_FIN2, S_PUSHL, S_ORD, S_OUT
  } state_t;
endpackage
`default_nettype wire

[rtl/qsl_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module qsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/quicksort_lomuto_unit.sv]
// Quicksort (Lomuto partition) unit: loads words, sorts in RAM, streams them out.
// Loading: one word per cycle while busy is low; the word marked last (or the
//   64th word) starts the sort. Sort: each compare and each swap (states S_SWR,
//   S_SWW) runs in turn, all on one element RAM port pair.
// Output: n result words on consecutive cycles, after the sort ends via S_ORD;
//   the receiver cannot stall. Next load may start the cycle after the last word.
// Reset (rst, synchronous) clears control, counts and stack pointer; the RAMs
//   are not cleared and need no clearing pass.
`default_nettype none
module quicksort_lomuto_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [qsl_pkg::DATA_W-1:0] element_value,
  input  wire logic                      element_last,
  output logic                           result_valid,
  output logic [qsl_pkg::DATA_W-1:0]     sorted_value,
  output logic                           result_last,
  output logic [qsl_pkg::CMP_W-1:0]      compare_count,
  output logic [qsl_pkg::SWP_W-1:0]      swap_count,
  output logic [qsl_pkg::ACC_W-1:0]      access_count
);
  import qsl_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0] count;     // words loaded = n during sort
  logic [SP_W-1:0]  sp;
  logic [IDX_W-1:0] lo, hi, j, nxt, k;
  logic [DATA_W-1:0] pivot, aj, an;
  logic [CMP_W-1:0] cmp;
  logic [SWP_W-1:0] swp;
  logic [ACC_W-1:0] acc;

  // element RAM
  logic              e_we;
  logic [IDX_W-1:0]  e_waddr, e_raddr;
  logic [DATA_W-1:0] e_wdata, e_rdata;
  // range stack RAM
  logic               s_we;
  logic [SP_W-2:0]    s_waddr, s_raddr;
  logic [RANGE_W-1:0] s_wdata, s_rdata;

  qsl_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_elem (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  qsl_ram #(.WIDTH(RANGE_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  logic accept, le, j1_lt_hi, j_lt_hi, push_r, push_l, out_end;
  logic [IDX_W-1:0] pop_lo, pop_hi;

  assign accept   = start && (state == S_IDLE);
  assign le       = $signed(e_rdata) <= $signed(pivot);
  assign j1_lt_hi = ({1'b0, j} + 1'b1) < {1'b0, hi};
  assign j_lt_hi  = j < hi;
  // right part p+1..hi and left part lo..p-1 need two or more words
  assign push_r   = ({1'b0, nxt} + 1'b1) < {1'b0, hi};
  assign push_l   = {1'b0, nxt} > ({1'b0, lo} + 1'b1);
  assign pop_lo   = s_rdata[RANGE_W-1:IDX_W];
  assign pop_hi   = s_rdata[IDX_W-1:0];
  assign out_end  = ({1'b0, k} + 1'b1) == count;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (element_last || count == CNT_W'(MAX_ELEMENTS - 1))) begin
          state_next = S_INIT;
        end
      end
      S_INIT:  state_next = (count < CNT_W'(2)) ? S_ORD : S_POP;
      S_POP:   state_next = (sp == '0) ? S_ORD : S_POPW;
      S_POPW:  state_next = (pop_lo >= pop_hi) ? S_POP : S_PIV;
      S_PIV:   state_next = S_CMP;
      S_CMP: begin
        if (le) begin
          state_next = S_SWR;
        end else if (!j1_lt_hi) begin
          state_next = S_FIN;
        end
      end
      S_SWR:   state_next = S_SWW;
      S_SWW:   state_next = S_NEXT;
      S_NEXT:  state_next = j_lt_hi ? S_CMP : S_FIN;
      S_FIN:   state_next = S_FIN2;
      S_FIN2:  state_next = S_PUSHL;
      S_PUSHL: state_next = S_POP;
      S_ORD:   state_next = S_OUT;
      S_OUT:   state_next = out_end ? S_IDLE : S_OUT;
      default: state_next = S_IDLE;
    endcase
  end

  // RAM control
  always_comb begin
    e_we    = 1'b0;
    e_waddr = nxt;
    e_wdata = aj;
    e_raddr = j;
    s_we    = 1'b0;
    s_waddr = sp[SP_W-2:0];
    s_wdata = {lo, hi};
    s_raddr = sp[SP_W-2:0] - 1'b1;
    unique case (state)
      S_IDLE: begin
        e_we    = accept;
        e_waddr = count[IDX_W-1:0];
        e_wdata = element_value;
      end
      S_INIT: begin
        s_we    = count >= CNT_W'(2);
        s_wdata = {IDX_W'(0), IDX_W'(count - 1'b1)};
      end
      S_POPW:  e_raddr = pop_hi;
      S_PIV:   e_raddr = lo;
      S_CMP: begin
        if (le || !j1_lt_hi) begin
          e_raddr = nxt;
        end else begin
          e_raddr = j + 1'b1;
        end
      end
      S_SWR: e_we = 1'b1;               // a[next] <= a[j]
      S_SWW: begin
        e_we    = 1'b1;                 // a[j] <= old a[next]
        e_waddr = j;
        e_wdata = an;
      end
      S_NEXT:  e_raddr = j_lt_hi ? j : nxt;
      S_FIN: begin
        e_we    = 1'b1;                 // pivot into place
        e_wdata = pivot;
      end
      S_FIN2: begin
        e_we    = 1'b1;
        e_waddr = hi;
        e_wdata = an;
        s_we    = push_r;
        s_wdata = {nxt + 1'b1, hi};
      end
      S_PUSHL: begin
        s_we    = push_l;
        s_wdata = {lo, nxt - 1'b1};
      end
      S_ORD:   e_raddr = '0;
      S_OUT:   e_raddr = k + 1'b1;
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      sp    <= '0;
      cmp   <= '0;
      swp   <= '0;
      acc   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: if (accept) count <= count + 1'b1;
        S_INIT: begin
          cmp <= '0;
          swp <= '0;
          acc <= '0;
          sp  <= (count >= CNT_W'(2)) ? SP_W'(1) : '0;
        end
        S_POP:  if (sp != '0) sp <= sp - 1'b1;
        S_POPW: begin
          lo <= pop_lo;
          hi <= pop_hi;
        end
        S_PIV: begin
          pivot <= e_rdata;
          j     <= lo;
          nxt   <= lo;
        end
        S_CMP: begin
          // counts cannot reach their field maximum with 64 words
          cmp <= cmp + 1'b1;
          acc <= acc + 1'b1;
          aj  <= e_rdata;
          if (!le) j <= j + 1'b1;
        end
        S_SWR: an <= e_rdata;
        S_SWW: begin
          swp <= swp + 1'b1;
          acc <= acc + ACC_W'(2);
          nxt <= nxt + 1'b1;
          j   <= j + 1'b1;
        end
        S_FIN: an <= e_rdata;
        S_FIN2: begin
          swp <= swp + 1'b1;
          acc <= acc + ACC_W'(2);
          if (push_r) sp <= sp + 1'b1;
        end
        S_PUSHL: if (push_l) sp <= sp + 1'b1;
        S_ORD:  k <= '0;
        S_OUT: begin
          if (out_end) begin
            count <= '0;
          end else begin
            k <= k + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign busy          = state != S_IDLE;
  assign result_valid  = state == S_OUT;
  assign sorted_value  = e_rdata;
  assign result_last   = (state == S_OUT) && out_end;
  assign compare_count = cmp;
  assign swap_count    = swp;
  assign access_count  = acc;

  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result word while idle");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_last |=> !busy) else $error("not idle after last word");
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH)) else $error("range stack overflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ELEMENTS)) else $error("element count overflow");
  a_stable_counts: assert property (@(posedge clk) disable iff (rst)
    (result_valid && $past(result_valid)) |-> $stable(acc))
    else $error("counts changed during output");
endmodule
`default_nettype wire

[dv/tb_top.sv]
// Testbench for the quicksort unit: random arrays, self-checking against a Lomuto predictor.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import qsl_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
    logic [CMP_W-1:0]  cmps;
    logic [SWP_W-1:0]  swps;
    logic [ACC_W-1:0]  accs;
  } sorted_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [DATA_W-1:0] element_value = '0;
  logic element_last = 1'b0;
  wire busy, result_valid, result_last;
  wire [DATA_W-1:0] sorted_value;
  wire [CMP_W-1:0] compare_count;
  wire [SWP_W-1:0] swap_count;
  wire [ACC_W-1:0] access_count;

  quicksort_lomuto_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .element_value(element_value), .element_last(element_last),
    .result_valid(result_valid), .sorted_value(sorted_value),
    .result_last(result_last), .compare_count(compare_count),
    .swap_count(swap_count), .access_count(access_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state: words collected for the array in progress
  logic signed [DATA_W-1:0] load_buf [MAX_ELEMENTS];
  int unsigned load_cnt = 0;
  sorted_word_t sorted_q[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int arrays_sent = 0;
  int send_idle_pct = 0;
  longint cycle_cnt = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %0s: got %0h want %0h (word %0d)", what, got, want, words_checked);
    errors++;
  endtask

  function automatic logic [31:0] sat(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] lim);
    logic [31:0] s;
    s = a + b;
    return (s > lim) ? lim : s;
  endfunction

  // Lomuto quicksort with explicit range stack; left part sorted first
  task automatic sort_and_queue(input int unsigned n);
    logic signed [DATA_W-1:0] a [MAX_ELEMENTS];
    logic signed [DATA_W-1:0] piv, t;
    int unsigned lo_stk[$], hi_stk[$];
    int unsigned lo, hi, nxt;
    logic [31:0] cmps, swps, accs;
    sorted_word_t w;
    cmps = 0; swps = 0; accs = 0;
    for (int i = 0; i < n; i++) a[i] = load_buf[i];
    if (n >= 2) begin
      lo_stk.push_back(0); hi_stk.push_back(n - 1);
    end
    while (lo_stk.size() > 0) begin
      lo = lo_stk.pop_back(); hi = hi_stk.pop_back();
      if (lo >= hi) continue;
      piv = a[hi]; nxt = lo;
      for (int unsigned j = lo; j < hi; j++) begin
        cmps = sat(cmps, 1, 4095); accs = sat(accs, 1, 8191);
        if (a[j] <= piv) begin
          t = a[nxt]; a[nxt] = a[j]; a[j] = t;
          swps = sat(swps, 1, 4095); accs = sat(accs, 2, 8191);
          nxt++;
        end
      end
      t = a[nxt]; a[nxt] = a[hi]; a[hi] = t;
      swps = sat(swps, 1, 4095); accs = sat(accs, 2, 8191);
      if (nxt + 1 < hi) begin
        lo_stk.push_back(nxt + 1); hi_stk.push_back(hi);
      end
      if (nxt > lo + 1) begin
        lo_stk.push_back(lo); hi_stk.push_back(nxt - 1);
      end
    end
    for (int k = 0; k < n; k++) begin
      w.value = a[k]; w.last = (k + 1 == n);
      w.cmps = cmps[CMP_W-1:0]; w.swps = swps[SWP_W-1:0]; w.accs = accs[ACC_W-1:0];
      sorted_q.push_back(w);
    end
  endtask

  // send one word; a random idle gap precedes it; inputs change on falling edges.
  // start stays high after the word so back-to-back words need one assignment.
  task automatic send_word(input logic [DATA_W-1:0] v, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1; element_value <= v; element_last <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge
    load_buf[load_cnt] = v;
    load_cnt++;
    words_sent++;
    if (lst || load_cnt == MAX_ELEMENTS) begin
      sort_and_queue(load_cnt);
      load_cnt = 0;
      arrays_sent++;
    end
    @(negedge clk);
  endtask

  task automatic send_array(input int n, input int kind);
    logic [DATA_W-1:0] v;
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: v = $urandom;
        1: v = $urandom_range(7) - 3;           // many duplicates
        2: v = i * 17;                           // ascending
        3: v = -i * 5;                           // descending
        default: v = ($urandom_range(1)) ? 32'h8000_0000 : 32'h7fff_ffff;
      endcase
      send_word(v, i == n - 1);
    end
  endtask

  // sender holds off until every expected word has come
  task automatic drain();
    start <= 1'b0;
    while (sorted_q.size() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // checker: result words sampled at rising edges
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst && result_valid) begin
      if (sorted_q.size() == 0) begin
        report_mismatch("unexpected word", sorted_value, 0);
      end else begin
        sorted_word_t w;
        w = sorted_q.pop_front();
        if (sorted_value !== w.value) report_mismatch("sorted_value", sorted_value, w.value);
        if (result_last !== w.last) report_mismatch("result_last", result_last, w.last);
        if (compare_count !== w.cmps) report_mismatch("compare_count", compare_count, w.cmps);
        if (swap_count !== w.swps) report_mismatch("swap_count", swap_count, w.swps);
        if (access_count !== w.accs) report_mismatch("access_count", access_count, w.accs);
      end
      words_checked++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_cnt > 2_000_000) begin
      $display("timeout at cycle %0d", cycle_cnt);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // directed: single word, two words, four words, duplicates, field extremes
  task automatic test_directed();
    send_word(32'h8000_0000, 1'b1);             // single element, zero counts
    send_word(32'h7fff_ffff, 1'b0);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h0, 1'b0);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'h5555_5555, 1'b0);
    send_word(32'haaaa_aaaa, 1'b1);
    drain();
    send_array(5, 1);
    send_array(6, 4);
    drain();
  endtask

  task automatic test_store_full();
    for (int i = 0; i < MAX_ELEMENTS; i++) send_word($urandom, 1'b0);
    drain();
    send_array(MAX_ELEMENTS, 3);
    drain();
  endtask

  task automatic test_random(input int idle_pct, input int words);
    int n;
    send_idle_pct = idle_pct;
    while (words > 0) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(MAX_ELEMENTS, 20) : $urandom_range(12, 1);
      send_array(n, $urandom_range(4));
      words -= n;
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 30;
    test_directed();
    test_store_full();
    test_random(30, 30);
    test_random(64, 30);
    test_random(0, 30);
    repeat (50) @(negedge clk);
    $display("sent %0d words in %0d arrays, checked %0d sorted words",
             words_sent, arrays_sent, words_checked);
    $display("covered single, store full, duplicates, ordered and extreme arrays");
    if (errors == 0 && sorted_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
